// ----- hw/rtl/tcfb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tcfb_pkg;

   // Panel geometry.
   localparam int PANEL_WIDTH  = 800;
   localparam int PANEL_HEIGHT = 480;

   // The store holds eight pixels of two bits in each word.
   localparam int PIXEL_COUNT = PANEL_WIDTH * PANEL_HEIGHT;
   localparam int LANES       = 8;
   localparam int SHADE_W     = 2;
   localparam int WORD_W      = LANES * SHADE_W;
   localparam int WORD_COUNT  = (PIXEL_COUNT + LANES - 1) / LANES;
   localparam int ADDR_W      = $clog2(WORD_COUNT + 1);
   localparam int IDX_W       = ADDR_W + 3;
   localparam int LAST_LANES  = PIXEL_COUNT - (WORD_COUNT - 1) * LANES;
   localparam int COL_W       = $clog2(PANEL_WIDTH + 1);
   localparam int ROW_W       = $clog2(PANEL_HEIGHT + 1);

   // Action codes.
   localparam logic [1:0] ACT_DRAW = 2'd0;
   localparam logic [1:0] ACT_FILL = 2'd1;
   localparam logic [1:0] ACT_READ = 2'd2;

   // Colour classes as they arrive on the request channel.
   localparam logic [1:0] COLOR_WHITE   = 2'd0;
   localparam logic [1:0] COLOR_BLACK   = 2'd1;
   localparam logic [1:0] COLOR_RED     = 2'd2;
   localparam logic [1:0] COLOR_RED_ALT = 2'd3;

   // Shade codes as they are kept in the store.
   localparam logic [1:0] SHADE_WHITE = 2'd0;
   localparam logic [1:0] SHADE_BLACK = 2'd1;
   localparam logic [1:0] SHADE_RED   = 2'd2;

   // Plane selection for reads.
   localparam logic PLANE_BLACK = 1'b0;
   localparam logic PLANE_RED   = 1'b1;

   // Rotation in quarter turns.
   localparam logic [1:0] ROT_0 = 2'd0;
   localparam logic [1:0] ROT_1 = 2'd1;
   localparam logic [1:0] ROT_2 = 2'd2;
   localparam logic [1:0] ROT_3 = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAP_A,
      ST_MAP_B,
      ST_DRAW_RD,
      ST_DRAW_WR,
      ST_READ_RD,
      ST_READ_OUT,
      ST_SWEEP
   } state_type;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [15:0] coord_x;
      logic signed [15:0] coord_y;
      logic [1:0]         color_class;
      logic               plane_select;
      logic [15:0]        byte_index;
   } cmd_type;

   // Result of the coordinate mapping: store word and pixel within it.
   typedef struct packed {
      logic              hit;
      logic [ADDR_W-1:0] word;
      logic [2:0]        lane;
   } map_type;

   function automatic logic [1:0] shade_of(input logic [1:0] cls);
      logic [1:0] s;
      case (cls) inside
         COLOR_RED, COLOR_RED_ALT: s = SHADE_RED;
         COLOR_BLACK:              s = SHADE_BLACK;
         default:                  s = SHADE_WHITE;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tcfb_channels.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface tcfb_req_if import tcfb_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic signed [15:0] coord_x;
   logic signed [15:0] coord_y;
   logic [1:0]         color_class;
   logic               plane_select;
   logic [15:0]        byte_index;

   modport source (output valid, action, coord_x, coord_y, color_class, plane_select,
                   byte_index, input ready);
   modport sink (input valid, action, coord_x, coord_y, color_class, plane_select,
                 byte_index, output ready);
endinterface

interface tcfb_rsp_if import tcfb_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] plane_byte;

   modport source (output valid, plane_byte, input ready);
   modport sink (input valid, plane_byte, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tricolor_framebuffer_plane_packer.sv -----
// Tricolour frame store with bit-plane read-out.
// The request channel takes one word per item: draw a pixel, fill the whole
// screen, or read one packed byte of the black or the red plane. Only reads
// produce a word on the response channel; draws and fills produce none.
// The rotation register is written through csr_write_en / csr_write_data
// and applies to the coordinates of later draws.
// Steps per item: a read fetches one store word and packs one byte from it;
// an in-range draw passes two mapping stages, then does a read-modify-write
// of one store word; an off-screen draw ends after the mapping stages; a fill
// sweeps the single write port of the store, one word of 8 pixels a cycle.
// After reset the same sweep paints the store white, so the request channel
// is held not ready until that sweep ends, before the first item.
// A read's byte waits in an output register; if the receiver stalls, the
// next item is still accepted, and only a second read waits for the slot.
`timescale 1ns / 1ps
`default_nettype none

module tricolor_framebuffer_plane_packer import tcfb_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   tcfb_req_if.sink        req_ch,
   tcfb_rsp_if.source      rsp_ch,
   input  wire logic       csr_write_en,
   input  wire logic [1:0] csr_write_data
);

   state_type         state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [1:0]        rot_ff, rot_in;
   logic [ADDR_W-1:0] sweep_addr_ff, sweep_addr_in;
   logic [1:0]        sweep_color_ff, sweep_color_in;
   logic              rd_hit_ff, rd_hit_in;
   logic              rd_last_ff, rd_last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;

   logic              ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
   logic [WORD_W-1:0] ram_wr_data, ram_rd_data;
   map_type           map;
   logic              accept;
   logic [31:0]       byte32;
   logic [7:0]        packed_byte;

   tcfb_addr_map u_map (
      .clock    (clock),
      .rotation (rot_ff),
      .coord_x  (cmd_ff.coord_x),
      .coord_y  (cmd_ff.coord_y),
      .map      (map)
   );

   tcfb_word_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign accept = req_ch.valid && req_ch.ready;
   assign byte32 = {16'd0, cmd_ff.byte_index};

   // Pack the eight pixels of the fetched word, first pixel in bit 7. Pixels
   // past the end of the store read as white.
   always_comb begin
      logic [1:0] shade;
      logic       live;
      packed_byte = '0;
      for (int k = 0; k < LANES; k++) begin
         shade = ram_rd_data[SHADE_W*k +: SHADE_W];
         live  = rd_hit_ff && !(rd_last_ff && (k >= LAST_LANES));
         if (!live) begin
            shade = SHADE_WHITE;
         end
         if (cmd_ff.plane_select == PLANE_RED) begin
            packed_byte[7-k] = (shade == SHADE_RED);
         end else begin
            packed_byte[7-k] = (shade != SHADE_BLACK);
         end
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      rot_in         = csr_write_en ? csr_write_data : rot_ff;
      sweep_addr_in  = sweep_addr_ff;
      sweep_color_in = sweep_color_ff;
      rd_hit_in      = rd_hit_ff;
      rd_last_in     = rd_last_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_byte_in    = rsp_byte_ff;
      req_ch.ready   = 1'b0;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = map.word;
      ram_wr_data    = ram_rd_data;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = map.word;

      unique case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (accept) begin
               cmd_in.action       = req_ch.action;
               cmd_in.coord_x      = req_ch.coord_x;
               cmd_in.coord_y      = req_ch.coord_y;
               cmd_in.color_class  = req_ch.color_class;
               cmd_in.plane_select = req_ch.plane_select;
               cmd_in.byte_index   = req_ch.byte_index;
               unique case (req_ch.action)
                  ACT_DRAW: state_in = ST_MAP_A;
                  ACT_READ: state_in = ST_READ_RD;
                  ACT_FILL: begin
                     state_in       = ST_SWEEP;
                     sweep_addr_in  = '0;
                     sweep_color_in = shade_of(req_ch.color_class);
                  end
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_MAP_A: state_in = ST_MAP_B;
         ST_MAP_B: state_in = ST_DRAW_RD;
         ST_DRAW_RD: begin
            if (map.hit) begin
               ram_rd_en = 1'b1;
               state_in  = ST_DRAW_WR;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DRAW_WR: begin
            // The word fetched last cycle goes back with one pixel replaced.
            ram_wr_en = 1'b1;
            ram_wr_data[SHADE_W*map.lane +: SHADE_W] = shade_of(cmd_ff.color_class);
            state_in  = ST_IDLE;
         end
         ST_READ_RD: begin
            rd_hit_in   = byte32 < 32'(WORD_COUNT);
            rd_last_in  = byte32 == 32'(WORD_COUNT - 1);
            ram_rd_addr = byte32[ADDR_W-1:0];
            ram_rd_en   = rd_hit_in;
            state_in    = ST_READ_OUT;
         end
         ST_READ_OUT: begin
            // The fetched word holds here until the output slot is free.
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = packed_byte;
               state_in     = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            ram_wr_en     = 1'b1;
            ram_wr_addr   = sweep_addr_ff;
            ram_wr_data   = {LANES{sweep_color_ff}};
            sweep_addr_in = sweep_addr_ff + ADDR_W'(1);
            if (sweep_addr_ff == ADDR_W'(WORD_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff         <= ROT_0;
         sweep_addr_ff  <= '0;
         sweep_color_ff <= SHADE_WHITE;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rot_ff         <= rot_in;
         sweep_addr_ff  <= sweep_addr_in;
         sweep_color_ff <= sweep_color_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      rd_hit_ff   <= rd_hit_in;
      rd_last_ff  <= rd_last_in;
      rsp_byte_ff <= rsp_byte_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.plane_byte = rsp_byte_ff;

   // The store never sees a read and a write in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("store read and write collide");

   // A draw write-back goes to the word fetched in the cycle before.
   assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && state_ff == ST_DRAW_WR) |->
         ($past(ram_rd_en) && $past(ram_rd_addr) == ram_wr_addr))
      else $error("draw write-back without matching fetch");

   // Items are only taken between operations, never during a sweep.
   assert property (@(posedge clock) disable iff (reset)
      accept |-> (state_ff == ST_IDLE))
      else $error("item accepted while busy");

   // A response word only appears out of the read formatting step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_READ_OUT))
      else $error("response word without a read");

   // The sweep stays inside the store.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (sweep_addr_ff < ADDR_W'(WORD_COUNT)))
      else $error("sweep address beyond the store");

endmodule

`default_nettype wire

// ----- hw/rtl/tcfb_word_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tcfb_word_ram import tcfb_pkg::*; (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WORD_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem_ff [WORD_COUNT];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/tcfb_addr_map.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tcfb_addr_map import tcfb_pkg::*; (
   input  wire logic               clock,
   input  wire logic [1:0]         rotation,
   input  wire logic signed [15:0] coord_x,
   input  wire logic signed [15:0] coord_y,
   output map_type                 map
);

   // First stage: bounds check and rotation. Second stage: raster index.
   logic             hit_ff, hit_in;
   logic [COL_W-1:0] px_ff, px_in;
   logic [ROW_W-1:0] py_ff, py_in;
   map_type          map_ff, map_in;

   logic [15:0]      xu, yu, lw, lh, px16, py16;
   logic [IDX_W-1:0] idx;

   always_comb begin
      xu = unsigned'(coord_x);
      yu = unsigned'(coord_y);
      lw = rotation[0] ? 16'(PANEL_HEIGHT) : 16'(PANEL_WIDTH);
      lh = rotation[0] ? 16'(PANEL_WIDTH) : 16'(PANEL_HEIGHT);
      hit_in = !xu[15] && !yu[15] && (xu < lw) && (yu < lh);
      case (rotation)
         ROT_1: begin
            px16 = 16'(PANEL_WIDTH - 1) - yu;
            py16 = xu;
         end
         ROT_2: begin
            px16 = 16'(PANEL_WIDTH - 1) - xu;
            py16 = 16'(PANEL_HEIGHT - 1) - yu;
         end
         ROT_3: begin
            px16 = yu;
            py16 = 16'(PANEL_HEIGHT - 1) - xu;
         end
         default: begin
            px16 = xu;
            py16 = yu;
         end
      endcase
      px_in = px16[COL_W-1:0];
      py_in = py16[ROW_W-1:0];
   end

   assign idx = IDX_W'(px_ff) + IDX_W'(py_ff) * IDX_W'(PANEL_WIDTH);

   always_comb begin
      map_in.hit  = hit_ff;
      map_in.word = idx[IDX_W-1:3];
      map_in.lane = idx[2:0];
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
      px_ff  <= px_in;
      py_ff  <= py_in;
      map_ff <= map_in;
   end

   assign map = map_ff;

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import tcfb_pkg::*;

   // Action code that the block must accept and then ignore.
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   // The fill and the clearing pass after reset each walk the whole store
   // once, so those dominate the run. The limit leaves several times the
   // slowest correct run.
   localparam int CYCLE_LIMIT  = 4_000_000;
   localparam int SETTLE_SHORT = 32;
   localparam int SETTLE_FILL  = WORD_COUNT + 32;

   // One expected plane byte, with the read that asked for it.
   typedef struct {
      logic [7:0]  value;
      logic        plane;
      logic [15:0] byte_index;
   } plane_byte_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_write_en;
   logic [1:0] csr_write_data;

   tcfb_req_if req_bus ();
   tcfb_rsp_if rsp_bus ();

   tricolor_framebuffer_plane_packer i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_bus),
      .rsp_ch         (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   // Our own copy of the frame: one shade per pixel in raster order, plus the
   // rotation register as last written.
   logic [1:0]     pixel_model [PIXEL_COUNT];
   logic [1:0]     rotation_model;
   plane_byte_type expected_plane_bytes [$];

   // Recently painted pixels, so that reads can be aimed at bytes that have
   // actually changed rather than at a sea of white.
   int drawn_pixels [$];

   int error_count   = 0;
   int bytes_checked = 0;
   int draws_sent    = 0;
   int fills_sent    = 0;
   int reads_sent    = 0;
   int ignored_sent  = 0;
   int burst_left    = 0;
   int fills_left    = 3;
   bit last_was_fill = 1'b0;
   bit calm          = 1'b0;

   logic [7:0] stall_pattern = 8'hFF;
   logic [5:0] stall_phase   = '0;

   always #1 clock = ~clock;

   // Whole run guard. If the block hangs, this is the only way out.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Timeout after %0d cycles", CYCLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // --------------------------------------------------------------------
   // Frame model
   // --------------------------------------------------------------------

   function automatic logic [1:0] class_to_shade(input logic [1:0] cls);
      case (cls)
         COLOR_WHITE: return SHADE_WHITE;
         COLOR_BLACK: return SHADE_BLACK;
         default:     return SHADE_RED;
      endcase
   endfunction

   // Maps a logical point through the current rotation to a raster index.
   // Points off the logical screen give -1 and are dropped by the caller.
   function automatic int map_to_index(input logic signed [15:0] x,
                                       input logic signed [15:0] y);
      int xi, yi, lw, lh, px, py;
      xi = x;
      yi = y;
      lw = rotation_model[0] ? PANEL_HEIGHT : PANEL_WIDTH;
      lh = rotation_model[0] ? PANEL_WIDTH : PANEL_HEIGHT;
      if (xi < 0 || xi >= lw || yi < 0 || yi >= lh) return -1;
      case (rotation_model)
         ROT_1: begin
            px = PANEL_WIDTH - 1 - yi;
            py = xi;
         end
         ROT_2: begin
            px = PANEL_WIDTH - 1 - xi;
            py = PANEL_HEIGHT - 1 - yi;
         end
         ROT_3: begin
            px = yi;
            py = PANEL_HEIGHT - 1 - xi;
         end
         default: begin
            px = xi;
            py = yi;
         end
      endcase
      return px + py * PANEL_WIDTH;
   endfunction

   // Packs eight pixels into one plane byte, first pixel in the top bit.
   // Pixels past the end of the store count as white.
   function automatic logic [7:0] pack_plane_byte(input logic plane,
                                                  input logic [15:0] byte_index);
      logic [7:0] packed_bits;
      logic [1:0] s;
      int         base;
      base = int'(byte_index) * 8;
      for (int k = 0; k < 8; k++) begin
         s = (base + k < PIXEL_COUNT) ? pixel_model[base + k] : SHADE_WHITE;
         if (plane == PLANE_RED) begin
            packed_bits[7 - k] = (s == SHADE_RED);
         end else begin
            packed_bits[7 - k] = (s != SHADE_BLACK);
         end
      end
      return packed_bits;
   endfunction

   // Applies one accepted word to the frame model and queues the byte that
   // a read must return.
   task automatic update_frame_model(input cmd_type c);
      plane_byte_type want;
      logic [1:0]     s;
      int             idx;
      last_was_fill = 1'b0;
      case (c.action)
         ACT_DRAW: begin
            draws_sent++;
            idx = map_to_index(c.coord_x, c.coord_y);
            if (idx >= 0) begin
               pixel_model[idx] = class_to_shade(c.color_class);
               drawn_pixels.push_back(idx);
               if (drawn_pixels.size() > 32) void'(drawn_pixels.pop_front());
            end
         end
         ACT_FILL: begin
            fills_sent++;
            last_was_fill = 1'b1;
            s = class_to_shade(c.color_class);
            for (int i = 0; i < PIXEL_COUNT; i++) pixel_model[i] = s;
         end
         ACT_READ: begin
            reads_sent++;
            want.value      = pack_plane_byte(c.plane_select, c.byte_index);
            want.plane      = c.plane_select;
            want.byte_index = c.byte_index;
            expected_plane_bytes.push_back(want);
         end
         default: begin
            ignored_sent++;
         end
      endcase
   endtask

   // --------------------------------------------------------------------
   // Request side
   // --------------------------------------------------------------------

   // Every word starts as random noise, so fields that an action ignores
   // are never left at a tidy value.
   function automatic cmd_type noise_word();
      cmd_type c;
      c.action       = 2'($urandom_range(0, 3));
      c.coord_x      = 16'($urandom());
      c.coord_y      = 16'($urandom());
      c.color_class  = 2'($urandom_range(0, 3));
      c.plane_select = 1'($urandom_range(0, 1));
      c.byte_index   = 16'($urandom());
      return c;
   endfunction

   function automatic cmd_type draw_word(input int x, input int y, input logic [1:0] cls);
      cmd_type c;
      c             = noise_word();
      c.action      = ACT_DRAW;
      c.coord_x     = 16'(x);
      c.coord_y     = 16'(y);
      c.color_class = cls;
      return c;
   endfunction

   function automatic cmd_type fill_word(input logic [1:0] cls);
      cmd_type c;
      c             = noise_word();
      c.action      = ACT_FILL;
      c.color_class = cls;
      return c;
   endfunction

   function automatic cmd_type read_word(input logic plane, input int byte_index);
      cmd_type c;
      c              = noise_word();
      c.action       = ACT_READ;
      c.plane_select = plane;
      c.byte_index   = 16'(byte_index);
      return c;
   endfunction

   // A value just inside or just outside one side of the logical screen.
   function automatic int border_value(input int limit);
      case ($urandom_range(0, 3))
         0:       return -1;
         1:       return 0;
         2:       return limit - 1;
         default: return limit;
      endcase
   endfunction

   // Sends one word. The sender works in bursts; at the start of each burst
   // it may drop valid for a random gap. Valid stays high from one word to
   // the next inside a burst, so it is never lowered and raised in one step.
   task automatic send_word(input cmd_type c);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap        = calm ? 0 : $urandom_range(0, 12);
         burst_left = $urandom_range(1, 16);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_bus.valid        <= 1'b1;
      req_bus.action       <= c.action;
      req_bus.coord_x      <= c.coord_x;
      req_bus.coord_y      <= c.coord_y;
      req_bus.color_class  <= c.color_class;
      req_bus.plane_select <= c.plane_select;
      req_bus.byte_index   <= c.byte_index;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      update_frame_model(c);
      burst_left--;
   endtask

   // Drops valid and waits until the block has nothing left to do: every
   // read answered, then enough cycles for a draw, or a whole fill sweep.
   task automatic go_quiet();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (expected_plane_bytes.size() != 0) @(posedge clock);
      repeat (last_was_fill ? SETTLE_FILL : SETTLE_SHORT) @(posedge clock);
   endtask

   // The rotation register is only written while the block is idle.
   task automatic set_rotation(input logic [1:0] rot);
      go_quiet();
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= rot;
      @(negedge clock);
      csr_write_en   <= 1'b0;
      csr_write_data <= 2'($urandom_range(0, 3));
      rotation_model = rot;
   endtask

   // --------------------------------------------------------------------
   // Result side
   // --------------------------------------------------------------------

   // The receiver stalls on a repeating pattern of ready bits that is chosen
   // afresh each time the phase counter wraps. At least a quarter of the
   // patterns never stall, and no pattern stalls for a whole period.
   always @(negedge clock) begin
      if (stall_phase == '0) begin
         if (calm || $urandom_range(0, 3) == 0) begin
            stall_pattern = 8'hFF;
         end else begin
            stall_pattern = 8'($urandom()) | 8'h01;
         end
      end
      rsp_bus.ready <= stall_pattern[stall_phase[2:0]];
      stall_phase   = stall_phase + 6'd1;
   end

   // Every plane byte that leaves the block is matched against the oldest
   // byte still owed.
   always @(posedge clock) begin
      plane_byte_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_plane_bytes.size() == 0) begin
            report_mismatch($sformatf("plane byte %02h with no read waiting",
                                      rsp_bus.plane_byte));
         end else begin
            want = expected_plane_bytes.pop_front();
            bytes_checked++;
            if (rsp_bus.plane_byte !== want.value) begin
               report_mismatch($sformatf("plane %0d byte %0d: got %02h, expected %02h",
                                         want.plane, want.byte_index,
                                         rsp_bus.plane_byte, want.value));
            end
         end
      end
   end

   // --------------------------------------------------------------------
   // Tests
   // --------------------------------------------------------------------

   // Straight after reset every pixel is white, including those beyond the
   // store that the highest byte index reaches.
   task automatic test_reset_white();
      send_word(read_word(PLANE_BLACK, 0));
      send_word(read_word(PLANE_RED, 16'hFFFF));
      send_word(read_word(PLANE_BLACK, WORD_COUNT - 1));
   endtask

   // Corner pixels at rotation 0, and points just off three sides of the
   // screen and at the ends of the coordinate range, which must be dropped.
   task automatic test_draw_edges();
      send_word(draw_word(0, 0, COLOR_BLACK));
      send_word(draw_word(PANEL_WIDTH - 1, PANEL_HEIGHT - 1, COLOR_RED_ALT));
      send_word(draw_word(-32768, 0, COLOR_BLACK));
      send_word(draw_word(0, 32767, COLOR_BLACK));
      send_word(draw_word(PANEL_WIDTH, 0, COLOR_BLACK));
      send_word(draw_word(0, PANEL_HEIGHT, COLOR_BLACK));
      send_word(draw_word(-1, 1, COLOR_RED));
      send_word(read_word(PLANE_BLACK, 0));
      send_word(read_word(PLANE_RED, WORD_COUNT - 1));
      send_word(read_word(PLANE_BLACK, PANEL_WIDTH / 8));
      send_word(read_word(PLANE_BLACK, PANEL_WIDTH / 8 - 1));
   endtask

   // Fills in each colour, each followed by one or two reads of one plane,
   // including the byte just past the end of the store.
   task automatic test_fill_colours();
      send_word(fill_word(COLOR_RED_ALT));
      send_word(read_word(PLANE_RED, 12345));
      send_word(fill_word(COLOR_BLACK));
      send_word(read_word(PLANE_BLACK, WORD_COUNT - 1));
      send_word(read_word(PLANE_BLACK, WORD_COUNT));
      send_word(fill_word(COLOR_WHITE));
      send_word(read_word(PLANE_RED, 0));
   endtask

   // An unused action code must leave the frame alone and return nothing.
   task automatic test_unused_action();
      cmd_type c;
      c             = draw_word(0, 0, COLOR_BLACK);
      c.action      = ACT_UNUSED;
      send_word(c);
      send_word(read_word(PLANE_BLACK, 0));
   endtask

   // Opposite corners at three quarter turns, plus a point that would be
   // on screen at rotation 0 but is off the narrower logical width here.
   task automatic test_rotation_corners();
      set_rotation(ROT_3);
      send_word(draw_word(0, 0, COLOR_BLACK));
      send_word(draw_word(PANEL_HEIGHT - 1, PANEL_WIDTH - 1, COLOR_RED));
      send_word(draw_word(PANEL_HEIGHT, 0, COLOR_BLACK));
      send_word(read_word(PLANE_BLACK, (PANEL_HEIGHT - 1) * PANEL_WIDTH / 8));
      send_word(read_word(PLANE_RED, PANEL_WIDTH / 8 - 1));
   endtask

   // Mixed traffic at one rotation. Draws land mostly on screen, so that
   // the mapping is exercised, with some along the borders and some
   // anywhere at all. Half the reads look at recently painted bytes.
   task automatic test_random_traffic(input logic [1:0] rot, input int count,
                                      input bit steady);
      cmd_type c;
      int      lw, lh, pick, done_words;
      set_rotation(rot);
      calm       = steady;
      done_words = 0;
      lw         = rot[0] ? PANEL_HEIGHT : PANEL_WIDTH;
      lh         = rot[0] ? PANEL_WIDTH : PANEL_HEIGHT;
      while (done_words < count) begin
         c    = noise_word();
         pick = $urandom_range(0, 999);
         if (pick < 3 && fills_left > 0) begin
            c.action = ACT_FILL;
            fills_left--;
            done_words++;
         end else if (pick < 15) begin
            c.action = ACT_UNUSED;
         end else if (pick < 500) begin
            c.action = ACT_DRAW;
            pick     = $urandom_range(0, 9);
            if (pick < 8) begin
               c.coord_x = 16'($urandom_range(0, lw - 1));
               c.coord_y = 16'($urandom_range(0, lh - 1));
            end else if (pick == 8) begin
               c.coord_x = 16'(border_value(lw));
               c.coord_y = 16'(border_value(lh));
            end
            done_words++;
         end else begin
            c.action = ACT_READ;
            pick     = $urandom_range(0, 19);
            if (pick < 10 && drawn_pixels.size() != 0) begin
               c.byte_index = 16'(drawn_pixels[$urandom_range(0, drawn_pixels.size() - 1)] / 8);
            end else if (pick < 17) begin
               c.byte_index = 16'($urandom_range(0, WORD_COUNT - 1));
            end else if (pick == 19) begin
               c.byte_index = 16'($urandom_range(WORD_COUNT - 4, WORD_COUNT + 3));
            end
            done_words++;
         end
         send_word(c);
      end
      calm = 1'b0;
   endtask

   // --------------------------------------------------------------------
   // Sequence
   // --------------------------------------------------------------------

   initial begin
      reset                = 1'b1;
      csr_write_en         = 1'b0;
      csr_write_data       = ROT_0;
      req_bus.valid        = 1'b0;
      req_bus.action       = ACT_DRAW;
      req_bus.coord_x      = '0;
      req_bus.coord_y      = '0;
      req_bus.color_class  = COLOR_WHITE;
      req_bus.plane_select = PLANE_BLACK;
      req_bus.byte_index   = '0;
      rotation_model       = ROT_0;
      for (int i = 0; i < PIXEL_COUNT; i++) pixel_model[i] = SHADE_WHITE;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The block holds off the first word while it clears the store.
      test_reset_white();
      test_draw_edges();
      test_fill_colours();
      test_unused_action();
      test_rotation_corners();

      test_random_traffic(ROT_1, 270, 1'b0);
      test_random_traffic(ROT_2, 270, 1'b1);
      test_random_traffic(ROT_3, 270, 1'b0);
      test_random_traffic(ROT_0, 270, 1'b0);
      test_random_traffic(2'($urandom_range(0, 3)), 270, 1'b1);
      test_random_traffic(2'($urandom_range(0, 3)), 270, 1'b0);

      go_quiet();
      if (expected_plane_bytes.size() != 0) begin
         report_mismatch($sformatf("%0d plane bytes never arrived",
                                   expected_plane_bytes.size()));
      end

      $display("Run covered %0d draws, %0d fills, %0d reads and %0d ignored words",
               draws_sent, fills_sent, reads_sent, ignored_sent);
      $display("over all four rotations; %0d plane bytes compared, %0d mismatches",
               bytes_checked, error_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/tcfb_pkg.sv
hw/rtl/tcfb_channels.sv
hw/rtl/tcfb_word_ram.sv
hw/rtl/tcfb_addr_map.sv
hw/rtl/tricolor_framebuffer_plane_packer.sv
tb/tb_top.sv
